// File: rtl/core/bwf_pkg.sv
// bwf_pkg: shared constants, port payload layouts and the queue item type
// for the bilinear feedback warp. No dependencies.

package bwf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int BANK_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(BANK_DEPTH);
  localparam int TOTAL_W    = ADDR_W + 1;

  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 8;
  localparam int IDX_W      = 16;

  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_NAT_W  = $clog2(MAX_DIM + 1);
  localparam int DIM_W      = (DIM_NAT_W > CFG_W) ? DIM_NAT_W : CFG_W;
  localparam int MIN_DIM    = 4;
  localparam int CFG_RESET_DIM = 256;
  localparam int RESET_WIDTH  = (CFG_RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET_DIM;
  localparam int RESET_HEIGHT = (CFG_RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET_DIM;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int PROD_W       = 2 * PIX_W;
  localparam int SUM_W        = PROD_W + 2;
  localparam int WEIGHT_SHIFT = 8;
  localparam int PIX_MAX      = 255;

  localparam int IN_DATA_W  = 7 * COORD_W;
  localparam int OUT_DATA_W = PIX_W + IDX_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = CFG_IDX_W'(1);

  // request kinds (in_tuser)
  localparam logic REQ_WARP = 1'b0;
  localparam logic REQ_PLOT = 1'b1;

  // in_tdata layout, lowest field last
  typedef struct packed {
    logic [PIX_W-1:0]   plot_value;
    logic [PIX_W-1:0]   weight_bottom_right;
    logic [PIX_W-1:0]   weight_bottom_left;
    logic [PIX_W-1:0]   weight_top_right;
    logic [PIX_W-1:0]   weight_top_left;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_x;
  } in_data_t;

  // out_tdata layout, lowest field last
  typedef struct packed {
    logic [IDX_W-1:0] dest_index;
    logic [PIX_W-1:0] pixel_value;
  } out_data_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic              is_plot;
    logic              mem_op;     // reads the source and writes one pixel
    logic              src_b;      // bank b is the source for this item
    logic [ADDR_W-1:0] addr_tl;
    logic [ADDR_W-1:0] addr_tr;
    logic [ADDR_W-1:0] addr_bl;
    logic [ADDR_W-1:0] addr_br;
    logic [ADDR_W-1:0] wr_addr;
    logic              frame_done;
    logic              plot_taken;
    logic [PIX_W-1:0]  w_tl;
    logic [PIX_W-1:0]  w_tr;
    logic [PIX_W-1:0]  w_bl;
    logic [PIX_W-1:0]  w_br;
    logic [PIX_W-1:0]  plot_value;
  } item_t;

endpackage

// File: rtl/core/bwf_ram.sv
// bwf_ram: generic single-write, dual-read RAM with registered read data.
// Standalone; no package dependency.

module bwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic                               re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                   rdata_a,
  output logic [WIDTH-1:0]                   rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_a_r <= mem_r[raddr_a];
      rd_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

// File: rtl/core/bwf_front.sv
// bwf_front: configuration registers, input acceptance and classification.
// Tracks the destination raster position and the source bank. Uses bwf_pkg.

module bwf_front
  import bwf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 clr_busy,
  input  logic                 q_ready,
  output logic                 q_push,
  output item_t                q_item
);

  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] ve;
    ve = DIM_W'(v);
    if (ve < DIM_W'(MIN_DIM)) begin
      sat_dim = DIM_W'(MIN_DIM);
    end else if (ve > DIM_W'(maxv)) begin
      sat_dim = DIM_W'(maxv);
    end else begin
      sat_dim = ve;
    end
  endfunction

  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [ADDR_W-1:0]  dest_r, dest_nxt;
  logic               src_b_r, src_b_nxt;

  in_data_t           d;
  logic               accept;
  logic               is_plot;
  logic [DIM_W-1:0]   wm2, hm2;
  logic [COORD_W-1:0] x_c, y_c;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  row;
  logic               in_window;
  logic               last_px;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACTIVE_WIDTH:  width_nxt  = sat_dim(cfg_data, MAX_WIDTH);
        REG_ACTIVE_HEIGHT: height_nxt = sat_dim(cfg_data, MAX_HEIGHT);
        default: ;
      endcase
    end
    total_nxt = TOTAL_W'(TOTAL_W'(width_nxt) * TOTAL_W'(height_nxt));
  end

  assign d         = in_tdata;
  assign in_tready = !clr_busy && q_ready;
  assign accept    = in_tvalid && in_tready;
  assign is_plot   = (in_tuser == REQ_PLOT);

  // clamp so the 2x2 neighborhood stays inside the frame
  assign wm2 = width_r - DIM_W'(2);
  assign hm2 = height_r - DIM_W'(2);
  assign x_c = (DIM_W'(d.pos_x) > wm2) ? COORD_W'(wm2) : d.pos_x;
  assign y_c = (DIM_W'(d.pos_y) > hm2) ? COORD_W'(hm2) : d.pos_y;
  assign base = ADDR_W'(ADDR_W'(y_c) * ADDR_W'(width_r)) + ADDR_W'(x_c);
  assign row  = ADDR_W'(width_r);

  assign in_window = (d.pos_x != '0) && (d.pos_y != '0)
                  && ((DIM_W + 1)'(d.pos_x) + (DIM_W + 1)'(3) < (DIM_W + 1)'(width_r))
                  && ((DIM_W + 1)'(d.pos_y) + (DIM_W + 1)'(3) < (DIM_W + 1)'(height_r));

  assign last_px = (TOTAL_W'(dest_r) + TOTAL_W'(1)) >= total_r;

  always_comb begin
    dest_nxt  = dest_r;
    src_b_nxt = src_b_r;
    if (accept && !is_plot) begin
      if (last_px) begin
        dest_nxt  = '0;
        src_b_nxt = !src_b_r;
      end else begin
        dest_nxt = dest_r + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    q_item            = '0;
    q_item.is_plot    = is_plot;
    q_item.src_b      = src_b_r;
    q_item.w_tl       = d.weight_top_left;
    q_item.w_tr       = d.weight_top_right;
    q_item.w_bl       = d.weight_bottom_left;
    q_item.w_br       = d.weight_bottom_right;
    q_item.plot_value = d.plot_value;
    if (is_plot) begin
      q_item.mem_op     = in_window;
      q_item.addr_tl    = base;
      q_item.addr_tr    = base;
      q_item.addr_bl    = base;
      q_item.addr_br    = base;
      q_item.wr_addr    = in_window ? base : '0;
      q_item.plot_taken = in_window;
    end else begin
      q_item.mem_op     = 1'b1;
      q_item.addr_tl    = base;
      q_item.addr_tr    = base + ADDR_W'(1);
      q_item.addr_bl    = base + row;
      q_item.addr_br    = base + row + ADDR_W'(1);
      q_item.wr_addr    = dest_r;
      q_item.frame_done = last_px;
    end
  end

  assign q_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(RESET_WIDTH);
      height_r <= DIM_W'(RESET_HEIGHT);
      total_r  <= TOTAL_W'(RESET_WIDTH * RESET_HEIGHT);
      dest_r   <= '0;
      src_b_r  <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      total_r  <= total_nxt;
      dest_r   <= dest_nxt;
      src_b_r  <= src_b_nxt;
    end
  end

endmodule

// File: rtl/core/bwf_fifo.sv
// bwf_fifo: short queue of classified items between front and back.
// Uses bwf_pkg for the item type and depth.

module bwf_fifo
  import bwf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  push_ready,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  item_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign push_ready = (count_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/core/bwf_back.sv
// bwf_back: frame bank memories, post-reset clearing pass and the
// read / multiply / accumulate / write pipeline. Uses bwf_pkg and bwf_ram.

module bwf_back
  import bwf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  output logic                  clr_busy,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser
);

  function automatic logic hits(input item_t it, input logic bank,
                                input logic [ADDR_W-1:0] a);
    hits = it.mem_op && (it.src_b == bank)
        && ((it.addr_tl == a) || (it.addr_tr == a) || (it.addr_bl == a) || (it.addr_br == a));
  endfunction

  // clearing pass
  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // read stage
  logic  s1_valid_r;
  item_t s1_item_r;
  logic  s1_wr_bank;

  // multiply stage
  logic              s2_valid_r;
  logic              s2_is_plot_r;
  logic              s2_mem_op_r;
  logic              s2_wr_bank_r;
  logic [ADDR_W-1:0] s2_wr_addr_r;
  logic              s2_done_r;
  logic              s2_taken_r;
  logic [PROD_W-1:0] s2_p_tl_r, s2_p_tr_r, s2_p_bl_r, s2_p_br_r;
  logic [PIX_W-1:0]  s2_plot_px_r;

  // output register
  logic      out_valid_r;
  out_data_t out_data_r;
  logic      out_last_r;
  logic      out_user_r;

  logic             adv;
  logic             hazard;
  logic             wr_en;
  logic             we_a, we_b;
  logic [ADDR_W-1:0] waddr;
  logic [PIX_W-1:0] wdata;

  logic [PIX_W-1:0] a_tl, a_tr, a_bl, a_br;
  logic [PIX_W-1:0] b_tl, b_tr, b_bl, b_br;
  logic [PIX_W-1:0] px_tl, px_tr, px_bl, px_br;
  logic [PIX_W-1:0] plot_px;

  logic [SUM_W-1:0]              sum;
  logic [SUM_W-WEIGHT_SHIFT-1:0] scaled;
  logic [PIX_W-1:0]              warp_px;
  logic [PIX_W-1:0]              px2;

  assign clr_busy = clr_busy_r;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(BANK_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  assign adv        = !out_valid_r || out_tready;
  assign s1_wr_bank = s1_item_r.is_plot ? s1_item_r.src_b : !s1_item_r.src_b;

  // writes land two stages after the read, so hold an item that reads
  // a pixel still being written by either item ahead of it
  assign hazard = (s1_valid_r && s1_item_r.mem_op
                   && hits(q_item, s1_wr_bank, s1_item_r.wr_addr))
               || (s2_valid_r && s2_mem_op_r
                   && hits(q_item, s2_wr_bank_r, s2_wr_addr_r));

  assign q_pop = q_valid && adv && !hazard && !clr_busy_r;

  // memory write port
  assign wr_en = s2_valid_r && s2_mem_op_r && adv;
  assign we_a  = clr_busy_r || (wr_en && !s2_wr_bank_r);
  assign we_b  = clr_busy_r || (wr_en && s2_wr_bank_r);
  assign waddr = clr_busy_r ? clr_addr_r : s2_wr_addr_r;
  assign wdata = clr_busy_r ? '0 : px2;

  // two copies per bank give four read ports for the 2x2 neighborhood
  bwf_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_ram_a0 (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .re(q_pop),
    .raddr_a(q_item.addr_tl), .raddr_b(q_item.addr_tr),
    .rdata_a(a_tl), .rdata_b(a_tr)
  );

  bwf_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_ram_a1 (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .re(q_pop),
    .raddr_a(q_item.addr_bl), .raddr_b(q_item.addr_br),
    .rdata_a(a_bl), .rdata_b(a_br)
  );

  bwf_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_ram_b0 (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .re(q_pop),
    .raddr_a(q_item.addr_tl), .raddr_b(q_item.addr_tr),
    .rdata_a(b_tl), .rdata_b(b_tr)
  );

  bwf_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_ram_b1 (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .re(q_pop),
    .raddr_a(q_item.addr_bl), .raddr_b(q_item.addr_br),
    .rdata_a(b_bl), .rdata_b(b_br)
  );

  // read stage: pick the source bank, multiply or max
  assign px_tl = s1_item_r.src_b ? b_tl : a_tl;
  assign px_tr = s1_item_r.src_b ? b_tr : a_tr;
  assign px_bl = s1_item_r.src_b ? b_bl : a_bl;
  assign px_br = s1_item_r.src_b ? b_br : a_br;

  always_comb begin
    plot_px = '0;
    if (s1_item_r.plot_taken) begin
      plot_px = (s1_item_r.plot_value > px_tl) ? s1_item_r.plot_value : px_tl;
    end
  end

  // multiply stage: sum, scale and saturate
  assign sum = SUM_W'(s2_p_tl_r) + SUM_W'(s2_p_tr_r) + SUM_W'(s2_p_bl_r) + SUM_W'(s2_p_br_r);
  assign scaled  = sum[SUM_W-1:WEIGHT_SHIFT];
  assign warp_px = (scaled > (SUM_W - WEIGHT_SHIFT)'(PIX_MAX)) ? PIX_W'(PIX_MAX)
                                                               : scaled[PIX_W-1:0];
  assign px2 = s2_is_plot_r ? s2_plot_px_r : warp_px;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item_r <= q_item;
    end
    if (adv) begin
      s2_is_plot_r <= s1_item_r.is_plot;
      s2_mem_op_r  <= s1_item_r.mem_op;
      s2_wr_bank_r <= s1_wr_bank;
      s2_wr_addr_r <= s1_item_r.wr_addr;
      s2_done_r    <= s1_item_r.frame_done;
      s2_taken_r   <= s1_item_r.plot_taken;
      s2_p_tl_r    <= PROD_W'(px_tl) * PROD_W'(s1_item_r.w_tl);
      s2_p_tr_r    <= PROD_W'(px_tr) * PROD_W'(s1_item_r.w_tr);
      s2_p_bl_r    <= PROD_W'(px_bl) * PROD_W'(s1_item_r.w_bl);
      s2_p_br_r    <= PROD_W'(px_br) * PROD_W'(s1_item_r.w_br);
      s2_plot_px_r <= plot_px;
      out_data_r.pixel_value <= px2;
      out_data_r.dest_index  <= IDX_W'(s2_wr_addr_r);
      out_last_r   <= s2_done_r;
      out_user_r   <= s2_taken_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (adv) begin
        s1_valid_r  <= q_pop;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

// File: rtl/core/bilinear_warp_feedback_frame.sv
// bilinear_warp_feedback_frame: top level of the feedback bilinear warp.
// Depends on bwf_pkg, bwf_front, bwf_fifo, bwf_back (and bwf_ram inside it).

// Two 8-bit frame banks swap roles as source and destination. A warp transfer
// (in_tuser low) reads the 2x2 source neighborhood at the clamped position,
// forms the weighted sum >> 8 saturated at 255 and writes it to the next
// destination pixel in raster order; the result whose out_tlast is high
// completed the frame and swapped the banks. A plot transfer (in_tuser high)
// max-writes plot_value into the source bank inside the allowed window and
// reports it with out_tuser high. Every input transfer yields exactly one
// result transfer, in order. Throughput is one item per clock while the
// result sink is ready; an item that reads a pixel which one of the two items
// ahead of it is still writing waits until that write lands, since the bank
// write port commits two stages after the read. Each item passes through the
// queue, the registered memory read, the multiply register and the output
// register. After reset both banks are cleared one address per cycle, with
// in_tready low; configuration writes are taken at any time but must only be
// issued while no item is in flight.

module bilinear_warp_feedback_frame
  import bwf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x, pos_y, weight_top_left, weight_top_right, weight_bottom_left,
  // weight_bottom_right, plot_value
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,   // req_type
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pixel_value, dest_index
  output logic                  out_tlast,  // frame_done
  output logic                  out_tuser   // plot_taken
);

  logic      clr_busy;
  logic      q_push;
  logic      q_ready;
  item_t     q_push_item;
  logic      q_pop;
  logic      q_valid;
  item_t     q_head;
  out_data_t od;

  bwf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clr_busy  (clr_busy),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  bwf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_head)
  );

  bwf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .clr_busy   (clr_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  assign od = out_tdata;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_tready)
    else $error("input accepted during bank clearing");

  a_clear_leaves_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy) |-> !out_tvalid && !q_valid)
    else $error("item in flight at end of bank clearing");

  a_done_only_on_warp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser)
    else $error("frame completion flagged on a plot result");

  a_plot_index_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> od.dest_index != '0)
    else $error("taken plot reported at index zero");

endmodule

// File: bench/testbench.sv
// testbench: self-checking regression for bilinear_warp_feedback_frame. Keeps a
// shadow copy of both frame banks, predicts every result and checks it in order.
// Depends on bwf_pkg and the block itself.

module testbench;
  import bwf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 300000;  // must exceed the bank clearing pass
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [IDX_W-1:0] dest_index;
    logic             frame_done;
    logic             plot_taken;
  } pixel_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  bilinear_warp_feedback_frame dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow state of the warp engine
  bit [PIX_W-1:0]   bank_copy [2][BANK_DEPTH];
  bit               src_is_b = 1'b0;
  int unsigned      raster_pos = 0;
  logic [CFG_W-1:0] width_reg = CFG_W'(256);
  logic [CFG_W-1:0] height_reg = CFG_W'(256);

  pixel_result_t expected_pixels [$];
  int unsigned   error_count = 0;
  int unsigned   result_count = 0;

  bit source_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  bit sink_hold = 1'b0;

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned lim);
    if (v < CFG_W'(MIN_DIM)) return MIN_DIM;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advances the shadow banks by one item and returns what the block must emit.
  function automatic pixel_result_t predict_pixel(logic req, in_data_t d);
    int unsigned   w, h, x, y, base, sum, idx, cur;
    int unsigned   src, dst;
    pixel_result_t r;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    x = 32'(d.pos_x);
    y = 32'(d.pos_y);
    src = src_is_b ? 1 : 0;
    dst = src_is_b ? 0 : 1;
    r = '0;
    if (req == REQ_WARP) begin
      if (x > w - 2) x = w - 2;
      if (y > h - 2) y = h - 2;
      base = y * w + x;
      sum = 32'(bank_copy[src][base]) * 32'(d.weight_top_left)
          + 32'(bank_copy[src][base + 1]) * 32'(d.weight_top_right)
          + 32'(bank_copy[src][base + w]) * 32'(d.weight_bottom_left)
          + 32'(bank_copy[src][base + w + 1]) * 32'(d.weight_bottom_right);
      sum = sum >> WEIGHT_SHIFT;
      if (sum > PIX_MAX) sum = PIX_MAX;
      idx = raster_pos;
      bank_copy[dst][idx % BANK_DEPTH] = PIX_W'(sum);
      // a frame shrunk below the counter also completes here
      if (idx + 1 >= w * h) begin
        raster_pos = 0;
        src_is_b = ~src_is_b;
        r.frame_done = 1'b1;
      end else begin
        raster_pos = idx + 1;
      end
      r.pixel_value = PIX_W'(sum);
      r.dest_index = IDX_W'(idx);
    end else if (x > 0 && x + 3 < w && y > 0 && y + 3 < h) begin
      idx = x + y * w;
      cur = 32'(bank_copy[src][idx]);
      if (32'(d.plot_value) > cur) cur = 32'(d.plot_value);
      bank_copy[src][idx] = PIX_W'(cur);
      r.pixel_value = PIX_W'(cur);
      r.dest_index = IDX_W'(idx);
      r.plot_taken = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (error_count < 50)
      $display("mismatch on result %0d, %s: got %0d, want %0d",
               result_count, what, got, want);
    error_count++;
  endtask

  task automatic send_item(logic req, in_data_t d);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    expected_pixels.push_back(predict_pixel(req, d));
    gap = source_gaps ? idle_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic set_frame_size(logic [CFG_W-1:0] width, logic [CFG_W-1:0] height);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_ACTIVE_WIDTH;
    cfg_data <= width;
    do @(posedge clk); while (!cfg_ready);
    width_reg = width;
    cfg_index <= REG_ACTIVE_HEIGHT;
    cfg_data <= height;
    do @(posedge clk); while (!cfg_ready);
    height_reg = height;
    cfg_valid <= 1'b0;
  endtask

  task automatic warp(int unsigned x, int unsigned y, int unsigned tl, int unsigned tr,
                      int unsigned bl, int unsigned br);
    in_data_t d;
    d = IN_DATA_W'({$urandom, $urandom});
    d.pos_x = COORD_W'(x);
    d.pos_y = COORD_W'(y);
    d.weight_top_left = PIX_W'(tl);
    d.weight_top_right = PIX_W'(tr);
    d.weight_bottom_left = PIX_W'(bl);
    d.weight_bottom_right = PIX_W'(br);
    send_item(REQ_WARP, d);
  endtask

  task automatic plot(int unsigned x, int unsigned y, int unsigned v);
    in_data_t d;
    d = IN_DATA_W'({$urandom, $urandom});
    d.pos_x = COORD_W'(x);
    d.pos_y = COORD_W'(y);
    d.plot_value = PIX_W'(v);
    send_item(REQ_PLOT, d);
  endtask

  task automatic send_random_item();
    in_data_t    d;
    logic        req;
    int unsigned w, h, r;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    d = IN_DATA_W'({$urandom, $urandom});
    req = ($urandom_range(0, 9) < 3) ? REQ_PLOT : REQ_WARP;
    if (req == REQ_PLOT) begin
      if (w > 4 && h > 4 && $urandom_range(0, 9) < 7) begin
        d.pos_x = COORD_W'($urandom_range(1, w - 4));
        d.pos_y = COORD_W'($urandom_range(1, h - 4));
      end
    end else begin
      if ($urandom_range(0, 9) < 6) begin
        d.pos_x = COORD_W'($urandom_range(0, w - 1));
        d.pos_y = COORD_W'($urandom_range(0, h - 1));
      end
      r = $urandom_range(0, 9);
      if (r < 4) begin
        // gentle weights keep the feedback loop from pinning at 0 or 255
        d.weight_top_left = PIX_W'($urandom_range(0, 100));
        d.weight_top_right = PIX_W'($urandom_range(0, 100));
        d.weight_bottom_left = PIX_W'($urandom_range(0, 100));
        d.weight_bottom_right = PIX_W'($urandom_range(0, 100));
      end else if (r < 6) begin
        d.weight_top_left = '0;
        d.weight_top_right = '0;
        d.weight_bottom_left = '0;
        d.weight_bottom_right = '0;
        case ($urandom_range(0, 3))
          0: d.weight_top_left = PIX_W'(PIX_MAX);
          1: d.weight_top_right = PIX_W'(PIX_MAX);
          2: d.weight_bottom_left = PIX_W'(PIX_MAX);
          default: d.weight_bottom_right = PIX_W'(PIX_MAX);
        endcase
      end
    end
    send_item(req, d);
  endtask

  // reset size 256x256: window edges, clamping, max-plot and saturation
  task automatic test_directed_edges();
    warp(0, 0, 255, 255, 255, 255);
    plot(1, 1, 200);
    plot(1, 1, 100);
    plot(2, 1, 255);
    plot(1, 2, 255);
    plot(2, 2, 255);
    warp(1, 1, 255, 255, 255, 255);
    warp(1, 1, 255, 0, 0, 0);
    warp(1, 1, 1, 0, 0, 0);
    warp(0, 0, 0, 0, 0, 255);
    plot(0, 5, 9);
    plot(5, 0, 9);
    plot(252, 252, 255);
    plot(253, 4, 7);
    plot(4, 253, 7);
    plot(255, 255, 255);
    warp(255, 255, 255, 255, 255, 255);
    warp(255, 0, 128, 128, 128, 128);
    warp(0, 255, 0, 255, 0, 255);
    plot(1, 1, 0);
    warp(251, 251, 0, 0, 0, 255);
  endtask

  // counter is far past a 4x4 frame: next warp must close the frame
  task automatic test_shrink_mid_frame();
    repeat (20) warp(3, 3, 64, 64, 64, 64);
    set_frame_size(CFG_W'(3), CFG_W'(0));
    warp(0, 0, 255, 0, 0, 0);
    repeat (40) send_random_item();
  endtask

  task automatic test_extreme_sizes();
    set_frame_size(CFG_W'(511), CFG_W'(3));
    repeat (120) send_random_item();
    set_frame_size(CFG_W'(2), CFG_W'(511));
    repeat (100) send_random_item();
    set_frame_size(CFG_W'(257), CFG_W'(256));
    repeat (30) send_random_item();
    set_frame_size(CFG_W'(6), CFG_W'(5));
    repeat (40) send_random_item();
  endtask

  task automatic test_backpressure();
    source_gaps = 1'b0;
    sink_hold = 1'b1;
    repeat (40) send_random_item();
    settle();
    source_gaps = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned r, n;
    logic [CFG_W-1:0] w, h;
    for (int phase = 0; phase < 12; phase++) begin
      r = $urandom_range(0, 9);
      if (r < 7) w = CFG_W'($urandom_range(4, 12));
      else if (r < 8) w = CFG_W'($urandom_range(0, 3));
      else if (r < 9) w = CFG_W'($urandom_range(13, 40));
      else w = CFG_W'($urandom_range(257, 511));
      r = $urandom_range(0, 9);
      if (r < 8) h = CFG_W'($urandom_range(4, 12));
      else h = CFG_W'($urandom_range(0, 3));
      set_frame_size(w, h);
      source_gaps = (phase % 3) != 1;
      sink_stalls = (phase % 4) != 2;
      n = $urandom_range(30, 60);
      repeat (n) send_random_item();
    end
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // result sink: random stalls plus an occasional long hold-off on request
  initial begin : result_sink
    int unsigned wait_left;
    wait_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        wait_left = SINK_HOLD_CYCLES;
        sink_hold = 1'b0;
      end else if (wait_left == 0 && sink_stalls) begin
        wait_left = idle_len();
      end
      if (wait_left > 0) begin
        out_tready <= 1'b0;
        wait_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    pixel_result_t want;
    out_data_t     got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with none pending, dest_index", 32'(got.dest_index), 0);
      end else begin
        want = expected_pixels.pop_front();
        if (got.pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", 32'(got.pixel_value), 32'(want.pixel_value));
        if (got.dest_index !== want.dest_index)
          report_mismatch("dest_index", 32'(got.dest_index), 32'(want.dest_index));
        if (out_tlast !== want.frame_done)
          report_mismatch("frame_done", 32'(out_tlast), 32'(want.frame_done));
        if (out_tuser !== want.plot_taken)
          report_mismatch("plot_taken", 32'(out_tuser), 32'(want.plot_taken));
      end
      result_count++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("bilinear_warp_feedback_frame regression: fail");
    $finish;
  end

  initial begin : main
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ACTIVE_WIDTH;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_WARP;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_shrink_mid_frame();
    test_extreme_sizes();
    test_backpressure();
    test_random_frames();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("bilinear_warp_feedback_frame regression: pass");
    end else begin
      $display("bilinear_warp_feedback_frame regression: fail");
    end
    $finish;
  end

endmodule

// File: bilinear_warp_feedback_frame.f
rtl/core/bwf_pkg.sv
rtl/core/bwf_ram.sv
rtl/core/bwf_front.sv
rtl/core/bwf_fifo.sv
rtl/core/bwf_back.sv
rtl/core/bilinear_warp_feedback_frame.sv
bench/testbench.sv
